FILE: rtl/assert_macros.svh
// Assertion macros used by the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("port assertion failed");

// Check that an expression never holds outside reset.
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
    `ASSERT_CLK(lbl, clk, rst_n, !(expr))

`endif

FILE: rtl/f2h_pkg.sv
// Types and constants for the single-to-half converter.
// No dependencies.
package f2h_pkg;

    localparam int SingleW = 32;
    localparam int HalfW   = 16;
    localparam int ExpW    = 8;
    localparam int FracW   = 23;
    localparam int SigW    = FracW + 1;
    localparam int HExpW   = 5;
    localparam int ShW     = 5;

    localparam logic [ExpW-1:0] EXP_ALL_ONES  = 8'hff;
    localparam logic [ExpW-1:0] EXP_INF_MIN   = 8'd143;
    localparam logic [ExpW-1:0] EXP_NORM_MIN  = 8'd113;
    localparam logic [ExpW-1:0] EXP_SUB_MIN   = 8'd102;
    localparam logic [ExpW-1:0] EXP_REBIAS    = 8'd112;
    localparam logic [ExpW-1:0] EXP_SHIFT_REF = 8'd126;

    localparam logic [FracW:0]    NORM_ROUND_ADD = 24'h001000;
    localparam logic [HalfW-2:0]  HALF_INF_MAG   = 15'h7c00;
    localparam logic [HalfW-2:0]  HALF_QNAN_MAG  = 15'h7e00;
    localparam logic [HalfW-2:0]  HALF_ZERO_MAG  = 15'h0000;

    typedef enum logic [2:0] {
        CLS_ZERO,
        CLS_SUB,
        CLS_NORM,
        CLS_INF,
        CLS_NAN
    } cls_t;

    typedef struct packed {
        logic             sign;
        cls_t             cls;
        logic [HExpW-1:0] reb;
        logic [ShW-1:0]   sh;
        logic [FracW-1:0] frac;
    } dec_t;

endpackage

FILE: rtl/float32_to_float16_convert.sv
// Top level: pipelined binary32 to binary16 converter.
// Depends on f2h_pkg and f2h_decode.
//
//  channel   handshake          payload
//  input     start / busy       single_bits[31:0]
//  result    done (strobe)      half_bits[15:0]
//
// One word enters per cycle; its result shows on done once it has passed every stage.
// The pipeline has three stages: decode, rounding add, subnormal shift and pack.
// busy stays low, as every stage advances each cycle.
// Reset clears the stage valid bits; payload registers are not reset.
module float32_to_float16_convert (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [f2h_pkg::SingleW-1:0]  single_bits,
    output logic                         done,
    output logic [f2h_pkg::HalfW-1:0]    half_bits
);
    import f2h_pkg::*;

    dec_t dec_next;
    dec_t dec_reg;
    logic va_reg;

    logic             vb_reg;
    logic             sign_b_reg;
    cls_t             cls_b_reg;
    logic [ShW-1:0]   sh_b_reg;
    logic [HalfW-2:0] norm_b_reg;
    logic [SigW:0]    rsum_b_reg;
    logic [HalfW-2:0] norm_b_next;
    logic [SigW:0]    rsum_b_next;
    logic [FracW:0]   frac_rnd;

    logic             done_reg;
    logic [HalfW-1:0] half_reg;
    logic [HalfW-1:0] half_next;
    logic [HalfW-2:0] mag;
    logic [SigW:0]    sub_shifted;

    f2h_decode u_decode (
        .word (single_bits),
        .dec  (dec_next)
    );

    assign frac_rnd    = {1'b0, dec_reg.frac} + NORM_ROUND_ADD;
    assign norm_b_next = {dec_reg.reb, {(HalfW-1-HExpW){1'b0}}}
                       + {{(HalfW-1-(FracW+1-13)){1'b0}}, frac_rnd[FracW:13]};
    assign rsum_b_next = {2'b01, dec_reg.frac}
                       + ({{SigW{1'b0}}, 1'b1} << (dec_reg.sh - 1'b1));

    assign sub_shifted = rsum_b_reg >> sh_b_reg;

    always_comb
    begin
        case (cls_b_reg)
            CLS_ZERO: mag = HALF_ZERO_MAG;
            CLS_SUB:  mag = sub_shifted[HalfW-2:0];
            CLS_NORM: mag = norm_b_reg;
            CLS_INF:  mag = HALF_INF_MAG;
            CLS_NAN:  mag = HALF_QNAN_MAG;
            default:  mag = HALF_ZERO_MAG;
        endcase
        half_next = {sign_b_reg, mag};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            va_reg   <= 1'b0;
            vb_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            va_reg   <= start;
            vb_reg   <= va_reg;
            done_reg <= vb_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dec_reg    <= dec_next;
        sign_b_reg <= dec_reg.sign;
        cls_b_reg  <= dec_reg.cls;
        sh_b_reg   <= dec_reg.sh;
        norm_b_reg <= norm_b_next;
        rsum_b_reg <= rsum_b_next;
        half_reg   <= half_next;
    end

    assign busy      = 1'b0;
    assign done      = done_reg;
    assign half_bits = half_reg;

endmodule

FILE: rtl/f2h_decode.sv
// Field split and class decode of a binary32 word.
// Depends on f2h_pkg.
module f2h_decode (
    input  logic [f2h_pkg::SingleW-1:0] word,
    output f2h_pkg::dec_t               dec
);
    import f2h_pkg::*;

    logic [ExpW-1:0]  ex;
    logic [FracW-1:0] frac;
    logic [ExpW-1:0]  reb_full;
    logic [ExpW-1:0]  sh_full;

    assign ex       = word[SingleW-2 -: ExpW];
    assign frac     = word[FracW-1:0];
    assign reb_full = ex - EXP_REBIAS;
    assign sh_full  = EXP_SHIFT_REF - ex;

    always_comb
    begin
        dec.sign = word[SingleW-1];
        dec.frac = frac;
        dec.reb  = reb_full[HExpW-1:0];
        dec.sh   = sh_full[ShW-1:0];
        if (ex == EXP_ALL_ONES)
        begin
            dec.cls = (frac != '0) ? CLS_NAN : CLS_INF;
        end
        else if (ex >= EXP_INF_MIN)
        begin
            dec.cls = CLS_INF;
        end
        else if (ex >= EXP_NORM_MIN)
        begin
            dec.cls = CLS_NORM;
        end
        else if (ex >= EXP_SUB_MIN)
        begin
            dec.cls = CLS_SUB;
        end
        else
        begin
            dec.cls = CLS_ZERO;
        end
    end

endmodule

FILE: rtl/f2h_checker.sv
// Port-level checker for the converter, bound to the top level.
// Depends on assert_macros.svh and f2h_pkg.
`include "assert_macros.svh"

module f2h_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         start,
    input logic                         busy,
    input logic [f2h_pkg::SingleW-1:0]  single_bits,
    input logic                         done,
    input logic [f2h_pkg::HalfW-1:0]    half_bits
);
    import f2h_pkg::*;

    logic             accepted;
    logic             nan_word;
    logic             in_sign;
    logic             out_sign;
    logic [HalfW-2:0] out_mag;

    assign accepted = start && !busy;
    assign nan_word = accepted
                   && (single_bits[SingleW-2 -: ExpW] == EXP_ALL_ONES)
                   && (single_bits[FracW-1:0] != '0);
    assign in_sign  = single_bits[SingleW-1];
    assign out_sign = half_bits[HalfW-1];
    assign out_mag  = half_bits[HalfW-2:0];

    `ASSERT_NEVER(busy_low, clk, rst_n, busy)
    `ASSERT_CLK(done_follows, clk, rst_n, accepted |=> ##2 done)
    `ASSERT_CLK(no_spurious_done, clk, rst_n, !accepted |=> ##2 !done)
    `ASSERT_CLK(sign_kept, clk, rst_n, accepted |=> ##2 (out_sign == $past(in_sign, 3)))
    `ASSERT_CLK(nan_quiet, clk, rst_n, nan_word |=> ##2 (out_mag == HALF_QNAN_MAG))

endmodule

bind float32_to_float16_convert f2h_checker u_f2h_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .single_bits (single_bits),
    .done        (done),
    .half_bits   (half_bits)
);
